[src/kar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kar_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam int FUNC_W  = 2;
    localparam int STAMP_W = 47;
    localparam int REF_W   = 16;
    localparam int COUNT_W = 11;

    localparam int SECS_W = 9;
    localparam int FPS_W  = 8;
    localparam int SPAN_W = SECS_W + FPS_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SECS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE     = 1'd1;

    localparam logic [SECS_W-1:0] SECONDS_MIN   = 9'd5;
    localparam logic [SECS_W-1:0] SECONDS_MAX   = 9'd300;
    localparam logic [SECS_W-1:0] SECONDS_RESET = 9'd30;
    localparam logic [FPS_W-1:0]  FPS_RESET     = 8'd30;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RETRIM = 2'd2;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic               video;
        logic               key;
        logic [REF_W-1:0]   payload;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[src/kar_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface kar_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [kar_pkg::FUNC_W-1:0]  func;
    logic [kar_pkg::STAMP_W-1:0] stamp;
    logic                        video_flag;
    logic                        key_flag;
    logic [kar_pkg::REF_W-1:0]   payload_ref;

    modport source (
        output valid, func, stamp, video_flag, key_flag, payload_ref,
        input  ready
    );
    modport sink (
        input  valid, func, stamp, video_flag, key_flag, payload_ref,
        output ready
    );
endinterface

interface kar_status_if;
    logic                        valid;
    logic                        ready;
    logic [kar_pkg::COUNT_W-1:0] dropped;
    logic [kar_pkg::COUNT_W-1:0] occupancy;
    logic                        overflowed;
    logic [kar_pkg::STAMP_W-1:0] oldest_stamp;
    logic                        holds_video;

    modport source (
        output valid, dropped, occupancy, overflowed, oldest_stamp, holds_video,
        input  ready
    );
    modport sink (
        input  valid, dropped, occupancy, overflowed, oldest_stamp, holds_video,
        output ready
    );
endinterface

`default_nettype wire

[src/keyframe_aligned_replay_window.sv]
// Each command item is taken in IDLE and passes through EXEC, SETTLE and TRIM;
// TRIM removes entries from the front of the ring, and the result item is
// registered once trimming stops and the previous result item has been taken.
// A new command item is accepted only after the result item is registered; the
// ring memory has a single read port, so the trim sequencer examines one front
// entry per cycle.
// Reset: pointers and counters clear at once, window 30 s and 30 fps; the ring
// memory is not cleared, as only occupied entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_aligned_replay_window (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    kar_cmd_if.sink                             cmd,
    kar_status_if.source                        status,
    input  wire logic                           cfg_we,
    input  wire logic [kar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kar_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SETTLE,
        ST_TRIM
    } state_t;

    state_t state_reg, state_next;

    logic [kar_pkg::FUNC_W-1:0]  func_reg, func_next;
    logic [kar_pkg::STAMP_W-1:0] item_stamp_reg, item_stamp_next;
    logic                        item_video_reg, item_video_next;
    logic                        item_key_reg, item_key_next;
    logic [kar_pkg::REF_W-1:0]   item_ref_reg, item_ref_next;

    logic [kar_pkg::PTR_W-1:0]   head_reg, head_next;
    logic [kar_pkg::PTR_W-1:0]   tail_reg, tail_next;
    logic [kar_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [kar_pkg::CNT_W-1:0]   vcount_reg, vcount_next;
    logic [kar_pkg::STAMP_W-1:0] newest_reg, newest_next;

    logic [kar_pkg::SECS_W-1:0]  secs_reg, secs_next;
    logic [kar_pkg::FPS_W-1:0]   fps_reg, fps_next;
    logic [kar_pkg::SPAN_W-1:0]  span_reg, span_next;
    logic [kar_pkg::SPAN_W-1:0]  span_fps_reg, span_fps_next;

    logic [kar_pkg::CNT_W-1:0]   drop_reg, drop_next;
    logic                        over_reg, over_next;
    logic                        trim_en_reg, trim_en_next;

    logic                        out_valid_reg, out_valid_next;
    logic [kar_pkg::COUNT_W-1:0] out_dropped_reg, out_dropped_next;
    logic [kar_pkg::COUNT_W-1:0] out_occ_reg, out_occ_next;
    logic                        out_over_reg, out_over_next;
    logic [kar_pkg::STAMP_W-1:0] out_oldest_reg, out_oldest_next;
    logic                        out_video_reg, out_video_next;

    logic                        ram_we;
    logic [kar_pkg::ENTRY_W-1:0] ram_rdata;
    kar_pkg::entry_t             wr_ent;
    kar_pkg::entry_t             head_ent;

    logic [kar_pkg::SECS_W-1:0]  secs_clamped;
    logic [kar_pkg::FPS_W-1:0]   fps_eff;
    logic [kar_pkg::SPAN_W-1:0]  span_prod;
    logic [kar_pkg::STAMP_W:0]   age;
    logic                        in_video_win;
    logic                        in_audio_win;
    logic                        keep_head;
    logic                        trim_pop;
    logic                        ring_full;
    logic [kar_pkg::PTR_W-1:0]   head_inc;
    logic [kar_pkg::PTR_W-1:0]   tail_inc;

    assign wr_ent.stamp   = item_stamp_reg;
    assign wr_ent.video   = item_video_reg;
    assign wr_ent.key     = item_key_reg;
    assign wr_ent.payload = item_ref_reg;

    // The read address follows the next head, so the registered read data holds the front
    // entry as the head register takes its new value, unless that entry is written at the same edge.
    kar_ram #(
        .WIDTH (kar_pkg::ENTRY_W),
        .DEPTH (kar_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (wr_ent),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    assign head_ent = kar_pkg::entry_t'(ram_rdata);

    always_comb
    begin
        if (secs_reg < kar_pkg::SECONDS_MIN)
        begin
            secs_clamped = kar_pkg::SECONDS_MIN;
        end
        else if (secs_reg > kar_pkg::SECONDS_MAX)
        begin
            secs_clamped = kar_pkg::SECONDS_MAX;
        end
        else
        begin
            secs_clamped = secs_reg;
        end
    end

    assign fps_eff   = (fps_reg == '0) ? kar_pkg::FPS_W'(1) : fps_reg;
    assign span_prod = kar_pkg::SPAN_W'(secs_clamped) * kar_pkg::SPAN_W'(fps_eff);

    // Age of the front entry against the newest video stamp; a negative age
    // always lies inside the window.
    assign age = {1'b0, newest_reg} - {1'b0, head_ent.stamp};
    assign in_video_win = $signed(age)
        <= $signed({(kar_pkg::STAMP_W + 1 - kar_pkg::SPAN_W)'(0), span_reg});
    assign in_audio_win = $signed(age)
        <= $signed({(kar_pkg::STAMP_W + 1 - kar_pkg::SPAN_W)'(0), span_fps_reg});
    assign keep_head = head_ent.video ? (in_video_win && head_ent.key) : in_audio_win;

    assign trim_pop = (state_reg == ST_TRIM) && trim_en_reg && (count_reg != '0)
                      && !keep_head;

    assign ring_full = (count_reg == kar_pkg::CNT_W'(kar_pkg::RING_DEPTH));
    assign head_inc  = (head_reg == kar_pkg::PTR_W'(kar_pkg::RING_DEPTH - 1))
                       ? '0 : head_reg + kar_pkg::PTR_W'(1);
    assign tail_inc  = (tail_reg == kar_pkg::PTR_W'(kar_pkg::RING_DEPTH - 1))
                       ? '0 : tail_reg + kar_pkg::PTR_W'(1);

    assign cmd.ready           = (state_reg == ST_IDLE);
    assign status.valid        = out_valid_reg;
    assign status.dropped      = out_dropped_reg;
    assign status.occupancy    = out_occ_reg;
    assign status.overflowed   = out_over_reg;
    assign status.oldest_stamp = out_oldest_reg;
    assign status.holds_video  = out_video_reg;

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        item_stamp_next  = item_stamp_reg;
        item_video_next  = item_video_reg;
        item_key_next    = item_key_reg;
        item_ref_next    = item_ref_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        vcount_next      = vcount_reg;
        newest_next      = newest_reg;
        secs_next        = secs_reg;
        fps_next         = fps_reg;
        span_next        = span_reg;
        span_fps_next    = span_fps_reg;
        drop_next        = drop_reg;
        over_next        = over_reg;
        trim_en_next     = trim_en_reg;
        out_valid_next   = out_valid_reg;
        out_dropped_next = out_dropped_reg;
        out_occ_next     = out_occ_reg;
        out_over_next    = out_over_reg;
        out_oldest_next  = out_oldest_reg;
        out_video_next   = out_video_reg;
        ram_we           = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                kar_pkg::CFG_WINDOW_SECONDS: secs_next = cfg_data;
                kar_pkg::CFG_FRAME_RATE:     fps_next  = cfg_data[kar_pkg::FPS_W-1:0];
                default:                     ;
            endcase
        end

        if (out_valid_reg && status.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next       = cmd.func;
                    item_stamp_next = cmd.stamp;
                    item_video_next = cmd.video_flag;
                    item_key_next   = cmd.key_flag;
                    item_ref_next   = cmd.payload_ref;
                    span_next       = span_prod;
                    state_next      = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                span_fps_next = span_reg + kar_pkg::SPAN_W'(fps_eff);
                drop_next     = '0;
                over_next     = 1'b0;
                trim_en_next  = (func_reg == kar_pkg::FUNC_PUSH)
                                || (func_reg == kar_pkg::FUNC_RETRIM);
                case (func_reg)
                    kar_pkg::FUNC_PUSH:
                    begin
                        // A full ring loses its oldest entry to make room.
                        if (ring_full)
                        begin
                            head_next   = head_inc;
                            over_next   = 1'b1;
                            vcount_next = vcount_reg
                                          - kar_pkg::CNT_W'(head_ent.video)
                                          + kar_pkg::CNT_W'(item_video_reg);
                        end
                        else
                        begin
                            count_next  = count_reg + kar_pkg::CNT_W'(1);
                            vcount_next = vcount_reg + kar_pkg::CNT_W'(item_video_reg);
                        end
                        ram_we    = 1'b1;
                        tail_next = tail_inc;
                        if (item_video_reg)
                        begin
                            newest_next = item_stamp_reg;
                        end
                    end

                    kar_pkg::FUNC_CLEAR:
                    begin
                        drop_next   = count_reg;
                        head_next   = '0;
                        tail_next   = '0;
                        count_next  = '0;
                        vcount_next = '0;
                        newest_next = '0;
                    end

                    default:
                    begin
                    end
                endcase
                state_next = ST_SETTLE;
            end

            ST_SETTLE:
            begin
                // Whether video is held is decided once, after the push has
                // landed; the trim then carries on through old audio even when
                // the last video entry has gone.
                trim_en_next = trim_en_reg && (vcount_reg != '0);
                state_next   = ST_TRIM;
            end

            ST_TRIM:
            begin
                if (trim_pop)
                begin
                    head_next   = head_inc;
                    count_next  = count_reg - kar_pkg::CNT_W'(1);
                    vcount_next = vcount_reg - kar_pkg::CNT_W'(head_ent.video);
                    drop_next   = drop_reg + kar_pkg::CNT_W'(1);
                end
                else if (!out_valid_reg || status.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_dropped_next = kar_pkg::COUNT_W'(drop_reg);
                    out_occ_next     = kar_pkg::COUNT_W'(count_reg);
                    out_over_next    = over_reg;
                    out_oldest_next  = (count_reg != '0) ? head_ent.stamp : '0;
                    out_video_next   = (vcount_reg != '0);
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            func_reg        <= '0;
            item_stamp_reg  <= '0;
            item_video_reg  <= 1'b0;
            item_key_reg    <= 1'b0;
            item_ref_reg    <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            vcount_reg      <= '0;
            newest_reg      <= '0;
            secs_reg        <= kar_pkg::SECONDS_RESET;
            fps_reg         <= kar_pkg::FPS_RESET;
            span_reg        <= '0;
            span_fps_reg    <= '0;
            drop_reg        <= '0;
            over_reg        <= 1'b0;
            trim_en_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_dropped_reg <= '0;
            out_occ_reg     <= '0;
            out_over_reg    <= 1'b0;
            out_oldest_reg  <= '0;
            out_video_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            func_reg        <= func_next;
            item_stamp_reg  <= item_stamp_next;
            item_video_reg  <= item_video_next;
            item_key_reg    <= item_key_next;
            item_ref_reg    <= item_ref_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            vcount_reg      <= vcount_next;
            newest_reg      <= newest_next;
            secs_reg        <= secs_next;
            fps_reg         <= fps_next;
            span_reg        <= span_next;
            span_fps_reg    <= span_fps_next;
            drop_reg        <= drop_next;
            over_reg        <= over_next;
            trim_en_reg     <= trim_en_next;
            out_valid_reg   <= out_valid_next;
            out_dropped_reg <= out_dropped_next;
            out_occ_reg     <= out_occ_next;
            out_over_reg    <= out_over_next;
            out_oldest_reg  <= out_oldest_next;
            out_video_reg   <= out_video_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kar_pkg::CNT_W'(kar_pkg::RING_DEPTH))
        else $error("ring occupancy beyond depth");

    a_video_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= count_reg)
        else $error("more video entries than entries");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == ST_EXEC))
        else $error("accepted item did not start execution");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        trim_pop |=> (count_reg == $past(count_reg) - kar_pkg::CNT_W'(1)))
        else $error("trim pop did not shrink the ring");

    a_result_from_trim: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || status.ready) && (state_reg == ST_TRIM) && !trim_pop
        |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished item did not reach the result register");

endmodule

`default_nettype wire

[src/kar_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module kar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam logic [kar_pkg::FUNC_W-1:0]  FUNC_SPARE   = 2'd3;
    localparam logic [kar_pkg::STAMP_W-1:0] STAMP_TOP    = '1;
    localparam logic [kar_pkg::STAMP_W-1:0] STAMP_MARGIN = 47'd1 << 30;
    localparam int                          HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [kar_pkg::FUNC_W-1:0]  func;
        logic [kar_pkg::STAMP_W-1:0] stamp;
        logic                        video_flag;
        logic                        key_flag;
        logic [kar_pkg::REF_W-1:0]   payload_ref;
    } cmd_item_t;

    typedef struct packed {
        logic [kar_pkg::COUNT_W-1:0] dropped;
        logic [kar_pkg::COUNT_W-1:0] occupancy;
        logic                        overflowed;
        logic [kar_pkg::STAMP_W-1:0] oldest_stamp;
        logic                        holds_video;
    } status_item_t;

    typedef struct {
        cmd_item_t    cmd;
        bit           typed;
        status_item_t want;
    } script_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [kar_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [kar_pkg::CFG_DATA_W-1:0] cfg_data;

    kar_cmd_if    cmd_bus ();
    kar_status_if status_bus ();

    keyframe_aligned_replay_window u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .status    (status_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the replay ring and its settings.
    logic [kar_pkg::STAMP_W-1:0] ring_stamp [kar_pkg::RING_DEPTH];
    bit                          ring_video [kar_pkg::RING_DEPTH];
    bit                          ring_key   [kar_pkg::RING_DEPTH];
    logic [kar_pkg::PTR_W-1:0]   ring_head;
    logic [kar_pkg::PTR_W-1:0]   ring_tail;
    int unsigned                 ring_count;
    int unsigned                 video_held;
    logic [kar_pkg::STAMP_W-1:0] newest_video;
    logic [kar_pkg::SECS_W-1:0]  win_secs;
    logic [kar_pkg::FPS_W-1:0]   win_fps;

    status_item_t status_q [$];
    status_item_t status_want;
    script_row_t  script [$];
    int unsigned  mismatches;
    bit           steady;
    int unsigned  holds_asked;
    int unsigned  holds_served;
    int unsigned  hold_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint frame_units();
        return (win_fps == 0) ? 1 : longint'(win_fps);
    endfunction

    function automatic longint window_span();
        longint secs;
        secs = win_secs;
        if (secs < kar_pkg::SECONDS_MIN)
            secs = kar_pkg::SECONDS_MIN;
        if (secs > kar_pkg::SECONDS_MAX)
            secs = kar_pkg::SECONDS_MAX;
        return secs * frame_units();
    endfunction

    function automatic void drop_front();
        if (ring_count == 0)
            return;
        if (ring_video[ring_head])
            video_held--;
        ring_head  = ring_head + 1'b1;
        ring_count--;
    endfunction

    // Walks the front of the ring, when any video is held, until it reaches a keyframe inside
    // the window, audio that is still recent enough to keep, or an empty ring.
    function automatic int unsigned trim_front();
        longint      span;
        longint      fps;
        longint      latest;
        longint      cutoff;
        longint      ts;
        int unsigned removed;
        bit          stop;
        removed = 0;
        stop    = 0;
        if (ring_count == 0 || video_held == 0)
            return 0;
        fps    = frame_units();
        span   = window_span();
        latest = newest_video;
        cutoff = latest - span;
        while (ring_count > 0 && !stop)
        begin
            ts = ring_stamp[ring_head];
            if (ring_video[ring_head])
                stop = (ts >= cutoff) && ring_key[ring_head];
            else
                stop = (latest - ts) <= (span + fps);
            if (!stop)
            begin
                drop_front();
                removed++;
            end
        end
        return removed;
    endfunction

    function automatic status_item_t window_apply(cmd_item_t c);
        status_item_t s;
        int unsigned  removed;
        bit           over;
        removed = 0;
        over    = 0;
        case (c.func)
            kar_pkg::FUNC_PUSH:
            begin
                if (ring_count >= kar_pkg::RING_DEPTH)
                begin
                    drop_front();
                    over = 1;
                end
                ring_stamp[ring_tail] = c.stamp;
                ring_video[ring_tail] = c.video_flag;
                ring_key[ring_tail]   = c.key_flag;
                ring_tail             = ring_tail + 1'b1;
                ring_count++;
                if (c.video_flag)
                begin
                    video_held++;
                    newest_video = c.stamp;
                end
                removed = trim_front();
            end
            kar_pkg::FUNC_CLEAR:
            begin
                removed      = ring_count;
                ring_head    = '0;
                ring_tail    = '0;
                ring_count   = 0;
                video_held   = 0;
                newest_video = '0;
            end
            kar_pkg::FUNC_RETRIM:
                removed = trim_front();
            default:
                removed = 0;
        endcase
        s.dropped      = kar_pkg::COUNT_W'(removed);
        s.occupancy    = kar_pkg::COUNT_W'(ring_count);
        s.overflowed   = over;
        s.oldest_stamp = (ring_count > 0) ? ring_stamp[ring_head] : '0;
        s.holds_video  = (video_held != 0);
        return s;
    endfunction

    function automatic status_item_t status_of(int dr, int occ, bit ov,
                                               logic [kar_pkg::STAMP_W-1:0] old, bit hv);
        status_item_t s;
        s.dropped      = kar_pkg::COUNT_W'(dr);
        s.occupancy    = kar_pkg::COUNT_W'(occ);
        s.overflowed   = ov;
        s.oldest_stamp = old;
        s.holds_video  = hv;
        return s;
    endfunction

    function automatic void add_row(logic [kar_pkg::FUNC_W-1:0] f,
                                    logic [kar_pkg::STAMP_W-1:0] st, bit v,
                                    bit k, logic [kar_pkg::REF_W-1:0] p, bit typed = 0,
                                    status_item_t want = '0);
        script_row_t r;
        r.cmd.func        = f;
        r.cmd.stamp       = st;
        r.cmd.video_flag  = v;
        r.cmd.key_flag    = k;
        r.cmd.payload_ref = p;
        r.typed           = typed;
        r.want            = want;
        script = {script, r};
    endfunction

    function automatic logic [kar_pkg::STAMP_W-1:0] base_stamp();
        logic [63:0]                 w;
        logic [kar_pkg::STAMP_W-1:0] b;
        w = {$urandom, $urandom};
        b = w[kar_pkg::STAMP_W-1:0];
        // Keep clear of both ends so a stream can grow upwards and audio can lag.
        if (b < STAMP_MARGIN)
            b = b + STAMP_MARGIN;
        if (b > STAMP_TOP - STAMP_MARGIN)
            b = b - STAMP_MARGIN;
        return b;
    endfunction

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && status_bus.valid && status_bus.ready)
        begin
            if (status_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result item with none expected, expected nothing actual %0h",
                         $time, status_bus.occupancy);
            end
            else
            begin
                status_want = status_q[0];
                status_q.delete(0);
                compare_field("dropped", status_want.dropped, status_bus.dropped);
                compare_field("occupancy", status_want.occupancy, status_bus.occupancy);
                compare_field("overflowed", status_want.overflowed, status_bus.overflowed);
                compare_field("oldest_stamp", status_want.oldest_stamp,
                              status_bus.oldest_stamp);
                compare_field("holds_video", status_want.holds_video, status_bus.holds_video);
            end
        end
    end

    // Result side: random stalls outside steady phases, and a long hold-off whenever one is asked for.
    initial
    begin
        status_bus.ready <= 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_served != holds_asked)
            begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                status_bus.ready <= 1'b0;
            end
            else
                status_bus.ready <= steady || ($urandom_range(99) >= 8);
        end
    end

    // Entered and left at a falling edge.
    task automatic send_item(cmd_item_t c, bit typed, status_item_t want);
        status_item_t predicted;
        while (!steady && $urandom_range(99) < 8)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.func        <= c.func;
        cmd_bus.stamp       <= c.stamp;
        cmd_bus.video_flag  <= c.video_flag;
        cmd_bus.key_flag    <= c.key_flag;
        cmd_bus.payload_ref <= c.payload_ref;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        predicted = window_apply(c);
        status_q  = {status_q, (typed ? want : predicted)};
        @(negedge clk);
    endtask

    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        @(negedge clk);
        while (status_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [kar_pkg::CFG_IDX_W-1:0] idx,
                             logic [kar_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == kar_pkg::CFG_WINDOW_SECONDS)
            win_secs = val;
        else
            win_fps = val[kar_pkg::FPS_W-1:0];
    endtask

    // Pushes keyframes and recent audio into a wide window so that nothing is trimmed and the
    // ring overflows, then clears it while full.
    task automatic fill_ring();
        cmd_item_t                   c;
        logic [kar_pkg::STAMP_W-1:0] b;
        drain_results();
        write_reg(kar_pkg::CFG_WINDOW_SECONDS, 9'd300);
        write_reg(kar_pkg::CFG_FRAME_RATE, 9'd240);
        b = base_stamp();
        c = '0;
        c.func = kar_pkg::FUNC_CLEAR;
        send_item(c, 0, '0);
        for (int i = 0; i < kar_pkg::RING_DEPTH + 24; i++)
        begin
            if (i == 300)
                holds_asked++;
            c.func        = kar_pkg::FUNC_PUSH;
            c.payload_ref = kar_pkg::REF_W'($urandom_range(16'hFFFF));
            c.stamp       = b + kar_pkg::STAMP_W'(i / 8);
            c.video_flag  = (i == 0) || ($urandom_range(99) < 70);
            c.key_flag    = c.video_flag ? 1'b1 : 1'($urandom_range(1));
            if (!c.video_flag)
                c.stamp = c.stamp - kar_pkg::STAMP_W'($urandom_range(100));
            send_item(c, 0, '0);
        end
        c.func = FUNC_SPARE;
        send_item(c, 0, '0);
        c.func = kar_pkg::FUNC_RETRIM;
        send_item(c, 0, '0);
        c.func = kar_pkg::FUNC_CLEAR;
        send_item(c, 0, '0);
    endtask

    // Mostly a plausible stream: video frames in groups led by a keyframe, with
    // audio trailing them, broken now and then by stray packets and commands.
    task automatic run_phase(int unsigned n_items, logic [kar_pkg::CFG_DATA_W-1:0] secs_val,
                             logic [kar_pkg::CFG_DATA_W-1:0] fps_val, bit calm,
                             bit pressure);
        cmd_item_t                   c;
        logic [kar_pkg::STAMP_W-1:0] vstamp;
        longint                      span;
        longint                      fps;
        int unsigned                 gop;
        int unsigned                 frame;
        int unsigned                 audio_left;
        int unsigned                 r;
        logic [63:0]                 w;
        drain_results();
        write_reg(kar_pkg::CFG_WINDOW_SECONDS, secs_val);
        write_reg(kar_pkg::CFG_FRAME_RATE, fps_val);
        steady     = calm;
        span       = window_span();
        fps        = frame_units();
        vstamp     = base_stamp();
        gop        = $urandom_range(1, 8);
        frame      = 0;
        audio_left = 0;
        c          = '0;
        c.func     = kar_pkg::FUNC_RETRIM;
        send_item(c, 0, '0);
        for (int k = 0; k < n_items; k++)
        begin
            if (pressure && k == 10)
                holds_asked++;
            if (pressure && k == n_items / 2)
                drain_results();
            r             = $urandom_range(99);
            w             = {$urandom, $urandom};
            c.func        = kar_pkg::FUNC_PUSH;
            c.stamp       = w[kar_pkg::STAMP_W-1:0];
            c.video_flag  = 1'($urandom_range(1));
            c.key_flag    = 1'($urandom_range(1));
            c.payload_ref = kar_pkg::REF_W'($urandom_range(16'hFFFF));
            if (r < 3)
                c.func = kar_pkg::FUNC_CLEAR;
            else if (r < 7)
                c.func = kar_pkg::FUNC_RETRIM;
            else if (r < 9)
                c.func = FUNC_SPARE;
            else if (r >= 13)
            begin
                if (audio_left > 0)
                begin
                    c.video_flag = 1'b0;
                    c.stamp = vstamp
                              - kar_pkg::STAMP_W'($urandom_range(int'(span + 2 * fps)));
                    audio_left--;
                end
                else
                begin
                    vstamp       = vstamp
                                   + kar_pkg::STAMP_W'($urandom_range(1, int'(span / 6) + 1));
                    c.video_flag = 1'b1;
                    c.key_flag   = (frame % gop == 0);
                    c.stamp      = vstamp;
                    frame++;
                    audio_left   = $urandom_range(2);
                end
            end
            // Anything else stays a push with random content, out of sequence.
            send_item(c, 0, '0);
        end
        steady = 0;
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= '0;
        cfg_data               <= '0;
        cmd_bus.valid          <= 1'b0;
        cmd_bus.func           <= kar_pkg::FUNC_PUSH;
        cmd_bus.stamp          <= '0;
        cmd_bus.video_flag     <= 1'b0;
        cmd_bus.key_flag       <= 1'b0;
        cmd_bus.payload_ref    <= '0;
        mismatches   = 0;
        steady       = 0;
        holds_asked  = 0;
        holds_served = 0;
        ring_head    = '0;
        ring_tail    = '0;
        ring_count   = 0;
        video_held   = 0;
        newest_video = '0;
        win_secs     = kar_pkg::SECONDS_RESET;
        win_fps      = kar_pkg::FPS_RESET;

        // Settings are at their reset values here: 30 s at 30 fps.
        add_row(FUNC_SPARE, '0, 0, 0, '0, 1, status_of(0, 0, 0, '0, 0));
        add_row(kar_pkg::FUNC_RETRIM, '0, 0, 0, '0, 1, status_of(0, 0, 0, '0, 0));
        add_row(kar_pkg::FUNC_PUSH, '0, 0, 1, 16'h0000, 1, status_of(0, 1, 0, '0, 0));
        add_row(kar_pkg::FUNC_PUSH, STAMP_TOP, 1, 1, 16'hFFFF, 1,
                status_of(1, 1, 0, STAMP_TOP, 1));
        add_row(kar_pkg::FUNC_PUSH, STAMP_TOP, 1, 0, 16'h5A5A);
        add_row(kar_pkg::FUNC_PUSH, STAMP_TOP - 47'd930, 0, 0, 16'hA5A5);
        add_row(FUNC_SPARE, STAMP_TOP, 1, 1, 16'hFFFF);
        add_row(kar_pkg::FUNC_CLEAR, '0, 0, 0, '0, 1, status_of(3, 0, 0, '0, 0));
        // A lone non-key video frame is trimmed away at once.
        add_row(kar_pkg::FUNC_PUSH, 47'd5, 1, 0, 16'h1234, 1, status_of(1, 0, 0, '0, 0));
        // Audio exactly at the window plus one second stays; one unit older goes.
        add_row(kar_pkg::FUNC_PUSH, 47'd1000, 0, 0, 16'h0F0F);
        add_row(kar_pkg::FUNC_PUSH, 47'd1930, 1, 0, 16'hF0F0);
        add_row(kar_pkg::FUNC_PUSH, 47'd1931, 1, 1, 16'h00FF);
        // A keyframe exactly at the cutoff stays; one unit later it goes.
        add_row(kar_pkg::FUNC_PUSH, 47'd2831, 1, 1, 16'hFF00);
        add_row(kar_pkg::FUNC_PUSH, 47'd2832, 1, 0, 16'h8001);
        add_row(kar_pkg::FUNC_PUSH, 47'd2000, 0, 1, 16'h7FFE);
        add_row(kar_pkg::FUNC_RETRIM, '0, 0, 0, '0);
        // Video stepping backwards puts the cutoff below zero.
        add_row(kar_pkg::FUNC_PUSH, 47'd10, 1, 1, 16'h4000);
        add_row(kar_pkg::FUNC_PUSH, 47'd3, 1, 0, 16'h0002);
        add_row(kar_pkg::FUNC_RETRIM, STAMP_TOP, 1, 1, 16'hFFFF);
        add_row(FUNC_SPARE, '0, 0, 0, '0);
        add_row(kar_pkg::FUNC_CLEAR, STAMP_TOP, 1, 1, 16'hFFFF);
        add_row(kar_pkg::FUNC_CLEAR, '0, 0, 0, '0, 1, status_of(0, 0, 0, '0, 0));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
            send_item(script[i].cmd, script[i].typed, script[i].want);

        fill_ring();

        run_phase(110, 9'd0, 9'd0, 0, 0);
        run_phase(110, 9'd300, 9'd240, 1, 0);
        run_phase(110, 9'h1FF, 9'h1FF, 0, 1);
        run_phase(100, 9'd5, 9'd1, 0, 0);
        for (int p = 0; p < 4; p++)
            run_phase(105, kar_pkg::CFG_DATA_W'($urandom_range(511)),
                      kar_pkg::CFG_DATA_W'($urandom_range(511)), 0, 0);

        cmd_bus.valid <= 1'b0;
        @(negedge clk);
        while (status_q.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (mismatches == 0 && status_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
